### src/nfsg_pkg.sv
// Shared types and constants for the NTSC field sync generator.
`default_nettype none

package nfsg_pkg;

  localparam int COL_W  = 12;
  localparam int LINE_W = 9;

  localparam int EQ_LINES_DEF     = 3;
  localparam int VSYNC_LINES_DEF  = 3;
  localparam int VBLANK_LINES_DEF = 15;
  localparam int FIELD_LINES_DEF  = 262;

  localparam logic [COL_W-1:0] LINE_TICKS_RST     = 12'd763;
  localparam logic [COL_W-1:0] HSYNC_TICKS_RST    = 12'd61;
  localparam logic [COL_W-1:0] VSYNC_HALF_END_RST = 12'd210;

  localparam logic [7:0] BIT_NOT_SYNC  = 8'h80;
  localparam logic [7:0] BIT_NOT_BLANK = 8'h08;

  typedef enum logic [1:0] {
    REG_LINE_TICKS     = 2'd0,
    REG_HSYNC_TICKS    = 2'd1,
    REG_VSYNC_HALF_END = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] line_ticks;
    logic [COL_W-1:0] hsync_ticks;
    logic [COL_W-1:0] vsync_half_end;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;
    logic              field_end;
  } pos_t;

endpackage

`default_nettype wire

### src/nfsg_position.sv
// Column and line counters that track the raster position within a field.
`default_nettype none

module nfsg_position #(
  parameter int FIELD_LINES = nfsg_pkg::FIELD_LINES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          advance,
  input  wire [nfsg_pkg::COL_W-1:0]    line_ticks,
  output nfsg_pkg::pos_t               pos
);
  import nfsg_pkg::*;

  logic [COL_W-1:0]  col;
  logic [LINE_W-1:0] line;
  logic              last_col;
  logic              last_line;

  assign last_col  = ({1'b0, col} + (COL_W+1)'(1)) >= {1'b0, line_ticks};
  assign last_line = ({1'b0, line} + (LINE_W+1)'(1)) >= (LINE_W+1)'(FIELD_LINES);

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      line <= '0;
    end else if (advance) begin
      if (last_col) begin
        col  <= '0;
        line <= last_line ? '0 : line + LINE_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  assign pos.col       = col;
  assign pos.line      = line;
  assign pos.field_end = last_col && last_line;

endmodule

`default_nettype wire

### src/nfsg_decode.sv
// Sync and blank decode of one raster position into the output byte.
`default_nettype none

module nfsg_decode #(
  parameter int EQ_LINES     = nfsg_pkg::EQ_LINES_DEF,
  parameter int VSYNC_LINES  = nfsg_pkg::VSYNC_LINES_DEF,
  parameter int VBLANK_LINES = nfsg_pkg::VBLANK_LINES_DEF
) (
  input  nfsg_pkg::cfg_t  cfg,
  input  nfsg_pkg::pos_t  pos,
  output logic [7:0]      rom_byte
);
  import nfsg_pkg::*;

  localparam logic [LINE_W-1:0] VS_START = LINE_W'(EQ_LINES);
  localparam logic [LINE_W-1:0] EQ2_START = LINE_W'(EQ_LINES + VSYNC_LINES);
  localparam logic [LINE_W-1:0] VB_START = LINE_W'(2 * EQ_LINES + VSYNC_LINES);
  localparam logic [LINE_W-1:0] ACT_START =
    LINE_W'(2 * EQ_LINES + VSYNC_LINES + VBLANK_LINES);

  logic [COL_W-1:0] half;
  logic [COL_W:0]   col_w;
  logic [COL_W:0]   half_w;
  logic [COL_W:0]   hs_w;
  logic             in_hsync;
  logic             eq_sync;
  logic             vs_sync;
  logic             sync;
  logic             blank;

  assign half   = {1'b0, cfg.line_ticks[COL_W-1:1]};
  assign col_w  = {1'b0, pos.col};
  assign half_w = {1'b0, half};
  assign hs_w   = {1'b0, cfg.hsync_ticks};

  assign in_hsync = pos.col < cfg.hsync_ticks;
  assign eq_sync  = in_hsync || (pos.col > half && col_w < half_w + hs_w);
  assign vs_sync  = (col_w + hs_w < half_w) ||
                    (pos.col > half && pos.col < cfg.vsync_half_end);

  always_comb begin
    blank = 1'b1;
    priority if (pos.line < VS_START) begin
      sync = eq_sync;
    end else if (pos.line < EQ2_START) begin
      sync = vs_sync;
    end else if (pos.line < VB_START) begin
      sync = eq_sync;
    end else if (pos.line < ACT_START) begin
      sync = in_hsync;
    end else begin
      sync  = in_hsync;
      blank = in_hsync;
    end
  end

  assign rom_byte = (sync ? 8'h00 : BIT_NOT_SYNC) | (blank ? 8'h00 : BIT_NOT_BLANK);

endmodule

`default_nettype wire

### src/ntsc_field_sync_generator.sv
// NTSC field sync generator top level: config registers, counters, output register.
// An accepted request's result is captured in the output register.
// Throughput: one request per cycle while m_tready is high; the output register refills while it is read.
// The counters advance at the request's edge when its tick bit is set, the decode runs from their old value.
// Reset (rst, synchronous): position goes to column 0, line 0, output empty,
// registers take their default timing values.
`default_nettype none

module ntsc_field_sync_generator #(
  parameter int EQ_LINES     = nfsg_pkg::EQ_LINES_DEF,
  parameter int VSYNC_LINES  = nfsg_pkg::VSYNC_LINES_DEF,
  parameter int VBLANK_LINES = nfsg_pkg::VBLANK_LINES_DEF,
  parameter int FIELD_LINES  = nfsg_pkg::FIELD_LINES_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [7:0]                 s_tdata,    // [0] tick, [7:1] zero
  output logic                       m_tvalid,
  input  wire                        m_tready,
  output logic [7:0]                 m_tdata,    // [7:0] rom_byte
  output logic                       m_tlast,    // field_end
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [1:0]                 cfg_index,
  input  wire  [nfsg_pkg::COL_W-1:0] cfg_data
);
  import nfsg_pkg::*;

  cfg_t       cfg;
  pos_t       pos;
  logic [7:0] rom_byte;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_ticks     <= LINE_TICKS_RST;
      cfg.hsync_ticks    <= HSYNC_TICKS_RST;
      cfg.vsync_half_end <= VSYNC_HALF_END_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_TICKS:     cfg.line_ticks     <= cfg_data;
        REG_HSYNC_TICKS:    cfg.hsync_ticks    <= cfg_data;
        REG_VSYNC_HALF_END: cfg.vsync_half_end <= cfg_data;
        default: ;
      endcase
    end
  end

  nfsg_position #(
    .FIELD_LINES(FIELD_LINES)
  ) u_position (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept && s_tdata[0]),
    .line_ticks (cfg.line_ticks),
    .pos        (pos)
  );

  nfsg_decode #(
    .EQ_LINES     (EQ_LINES),
    .VSYNC_LINES  (VSYNC_LINES),
    .VBLANK_LINES (VBLANK_LINES)
  ) u_decode (
    .cfg      (cfg),
    .pos      (pos),
    .rom_byte (rom_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= rom_byte;
      m_tlast <= pos.field_end;
    end
  end

endmodule

`default_nettype wire

### src/nfsg_checker.sv
// Port-level checks for the NTSC field sync generator, bound to the top level.
`default_nettype none

module nfsg_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tready,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata,
  input wire       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_unused_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata & 8'h77) == 8'h00)
    else $error("unused output bits set");

  a_sync_blanks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[7] |-> !m_tdata[3])
    else $error("sync without blanking");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("not ready with empty output");

endmodule

bind ntsc_field_sync_generator nfsg_checker u_nfsg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
